[src/stq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF   = 48;
   localparam int PORT_TIME_BITS  = 48;
   localparam int TICKET_BITS     = 32;
   localparam int MAX_RESULTS     = 16;
   localparam int POP_CNT_BITS    = $clog2(MAX_RESULTS);

   // Request kinds carried on req_tuser.
   localparam logic [1:0] REQ_SCHEDULE   = 2'd0;
   localparam logic [1:0] REQ_CANCEL     = 2'd1;
   localparam logic [1:0] REQ_RESCHEDULE = 2'd2;
   localparam logic [1:0] REQ_TICK       = 2'd3;

   // Result status codes carried on rsp_tuser.
   localparam logic [2:0] STAT_SCHEDULED   = 3'd0;
   localparam logic [2:0] STAT_CANCELLED   = 3'd1;
   localparam logic [2:0] STAT_NOT_FOUND   = 3'd2;
   localparam logic [2:0] STAT_RESCHEDULED = 3'd3;
   localparam logic [2:0] STAT_EXPIRED     = 3'd4;
   localparam logic [2:0] STAT_FULL        = 3'd5;
   localparam logic [2:0] STAT_NO_TICKET   = 3'd6;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_INSERT,
      OP_REMOVE,
      OP_POP
   } cell_op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RESCH,
      S_TICK
   } state_type;

   // Flags handed from one cell to the next one down the row.
   typedef struct packed {
      logic keep;   // this cell holds a timer due no later than the new one
      logic match;  // the ticket was found in this cell or an earlier one
   } link_type;

endpackage

`default_nettype wire

[src/stq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module stq_cell #(
   parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  stq_pkg::cell_op_type             cmd_op,
   input  wire  [TIME_BITS-1:0]             cmd_due,
   input  wire  [stq_pkg::TICKET_BITS-1:0]  cmd_ticket,
   input  wire                              prev_valid,
   input  wire  [TIME_BITS-1:0]             prev_due,
   input  wire  [stq_pkg::TICKET_BITS-1:0]  prev_ticket,
   input  stq_pkg::link_type                link_in,
   input  wire                              next_valid,
   input  wire  [TIME_BITS-1:0]             next_due,
   input  wire  [stq_pkg::TICKET_BITS-1:0]  next_ticket,
   output logic                             valid,
   output logic [TIME_BITS-1:0]             due,
   output logic [stq_pkg::TICKET_BITS-1:0]  ticket,
   output stq_pkg::link_type                link_out
);

   logic                             valid_ff, valid_in;
   logic [TIME_BITS-1:0]             due_ff, due_in;
   logic [stq_pkg::TICKET_BITS-1:0]  ticket_ff, ticket_in;
   logic                             keep_here;
   logic                             match_here;

   assign keep_here  = valid_ff && (due_ff <= cmd_due);
   assign match_here = valid_ff && (ticket_ff == cmd_ticket);

   assign link_out.keep  = keep_here;
   assign link_out.match = link_in.match | match_here;

   always_comb begin
      valid_in  = valid_ff;
      due_in    = due_ff;
      ticket_in = ticket_ff;
      case (cmd_op)
         stq_pkg::OP_INSERT: begin
            // Cells past the insertion point shift down by one.
            if (!keep_here) begin
               if (link_in.keep) begin
                  valid_in  = 1'b1;
                  due_in    = cmd_due;
                  ticket_in = cmd_ticket;
               end else begin
                  valid_in  = prev_valid;
                  due_in    = prev_due;
                  ticket_in = prev_ticket;
               end
            end
         end
         stq_pkg::OP_REMOVE: begin
            if (link_out.match) begin
               valid_in  = next_valid;
               due_in    = next_due;
               ticket_in = next_ticket;
            end
         end
         stq_pkg::OP_POP: begin
            valid_in  = next_valid;
            due_in    = next_due;
            ticket_in = next_ticket;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff    <= due_in;
      ticket_ff <= ticket_in;
   end

   assign valid  = valid_ff;
   assign due    = due_ff;
   assign ticket = ticket_ff;

endmodule

`default_nettype wire

[src/sorted_timer_ticket_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata                                        tuser          tlast
// req_      in         [31:0] ticket, [79:32] due, [127:80] now     [1:0] kind     -
// rsp_      out        [31:0] ticket_out, [79:32] expired_time      [2:0] status   last
//
// A reschedule first removes the timer and then re-inserts it through the cell row. A tick
// first latches the current time, then pops one expired timer per cycle while the output
// register is free, at most 16 per tick. Reset clears all valid bits and the ticket counter.
// A result waits in the output register while rsp_tready is low; pops then hold and no new
// request is taken.

module sorted_timer_ticket_queue_core #(
   parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF,
   parameter int TIME_BITS   = stq_pkg::TIME_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [127:0] req_tdata,   // ticket, due_time, now_time
   input  wire  [1:0]   req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [79:0]  rsp_tdata,   // ticket_out, expired_time
   output logic [2:0]   rsp_tuser,   // status
   output logic         rsp_tlast    // last
);

   localparam int TKB = stq_pkg::TICKET_BITS;
   localparam int PTB = stq_pkg::PORT_TIME_BITS;
   localparam int PCB = stq_pkg::POP_CNT_BITS;

   // Request fields.
   logic [1:0]               req_kind;
   logic [TKB-1:0]           req_ticket;
   logic [TIME_BITS+PTB-1:0] due_wide, now_wide;
   logic [TIME_BITS-1:0]     req_due, req_now;

   assign req_kind   = req_tuser;
   assign req_ticket = req_tdata[31:0];
   assign due_wide   = {{TIME_BITS{1'b0}}, req_tdata[79:32]};
   assign now_wide   = {{TIME_BITS{1'b0}}, req_tdata[127:80]};
   assign req_due    = due_wide[TIME_BITS-1:0];
   assign req_now    = now_wide[TIME_BITS-1:0];

   // Cell row.
   stq_pkg::cell_op_type     cmd_op;
   logic [TIME_BITS-1:0]     cmd_due;
   logic [TKB-1:0]           cmd_ticket;
   logic [QUEUE_DEPTH-1:0]   valid_vec;
   logic [TIME_BITS-1:0]     due_arr    [QUEUE_DEPTH];
   logic [TKB-1:0]           ticket_arr [QUEUE_DEPTH];
   stq_pkg::link_type        link_arr   [QUEUE_DEPTH];
   stq_pkg::link_type        link_head;

   assign link_head.keep  = 1'b1;
   assign link_head.match = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 p_valid, n_valid;
      logic [TIME_BITS-1:0] p_due, n_due;
      logic [TKB-1:0]       p_ticket, n_ticket;
      stq_pkg::link_type    p_link;

      if (i == 0) begin : g_first
         assign p_valid  = 1'b0;
         assign p_due    = '0;
         assign p_ticket = '0;
         assign p_link   = link_head;
      end else begin : g_mid
         assign p_valid  = valid_vec[i-1];
         assign p_due    = due_arr[i-1];
         assign p_ticket = ticket_arr[i-1];
         assign p_link   = link_arr[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign n_valid  = 1'b0;
         assign n_due    = '0;
         assign n_ticket = '0;
      end else begin : g_inner
         assign n_valid  = valid_vec[i+1];
         assign n_due    = due_arr[i+1];
         assign n_ticket = ticket_arr[i+1];
      end

      stq_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd_op      (cmd_op),
         .cmd_due     (cmd_due),
         .cmd_ticket  (cmd_ticket),
         .prev_valid  (p_valid),
         .prev_due    (p_due),
         .prev_ticket (p_ticket),
         .link_in     (p_link),
         .next_valid  (n_valid),
         .next_due    (n_due),
         .next_ticket (n_ticket),
         .valid       (valid_vec[i]),
         .due         (due_arr[i]),
         .ticket      (ticket_arr[i]),
         .link_out    (link_arr[i])
      );
   end

   // Control state.
   stq_pkg::state_type   state_ff, state_in;
   logic [TKB-1:0]       ticket_cnt_ff, ticket_cnt_in, ticket_next;
   logic [PCB-1:0]       pop_cnt_ff, pop_cnt_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] resch_due_ff, resch_due_in;
   logic [TKB-1:0]       resch_ticket_ff, resch_ticket_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [TKB-1:0] rsp_ticket_ff, rsp_ticket_in;
   logic [PTB-1:0] rsp_time_ff, rsp_time_in;
   logic           rsp_last_ff, rsp_last_in;

   logic out_free, accept, full, found;
   logic head_due, next_due, tick_last;
   logic emit;
   logic [2:0]     emit_status;
   logic [TKB-1:0] emit_ticket;
   logic [PTB-1:0] emit_time;
   logic           emit_last;
   logic [TIME_BITS+PTB-1:0] head_wide;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == stq_pkg::S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = valid_vec[QUEUE_DEPTH-1];
   assign found      = link_arr[QUEUE_DEPTH-1].match;
   assign ticket_next = (ticket_cnt_ff == '1) ? TKB'(1) : ticket_cnt_ff + 1'b1;

   assign head_due  = valid_vec[0] && (due_arr[0] < now_ff);
   assign next_due  = valid_vec[1] && (due_arr[1] < now_ff);
   assign tick_last = !next_due || (pop_cnt_ff == PCB'(stq_pkg::MAX_RESULTS - 1));
   assign head_wide = {{PTB{1'b0}}, due_arr[0]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stq_pkg::S_IDLE: begin
            if (accept) begin
               if (req_kind == stq_pkg::REQ_TICK) begin
                  state_in = stq_pkg::S_TICK;
               end else if (req_kind == stq_pkg::REQ_RESCHEDULE && req_ticket != '0 && found) begin
                  state_in = stq_pkg::S_RESCH;
               end
            end
         end
         stq_pkg::S_RESCH: begin
            state_in = stq_pkg::S_IDLE;
         end
         stq_pkg::S_TICK: begin
            if (!head_due || (out_free && tick_last)) begin
               state_in = stq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = stq_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs of the state machine: commands to the cells and results.
   always_comb begin
      cmd_op          = stq_pkg::OP_NOP;
      cmd_due         = req_due;
      cmd_ticket      = req_ticket;
      emit            = 1'b0;
      emit_status     = stq_pkg::STAT_SCHEDULED;
      emit_ticket     = '0;
      emit_time       = '0;
      emit_last       = 1'b1;
      ticket_cnt_in   = ticket_cnt_ff;
      pop_cnt_in      = pop_cnt_ff;
      now_in          = now_ff;
      resch_due_in    = resch_due_ff;
      resch_ticket_in = resch_ticket_ff;
      unique case (state_ff)
         stq_pkg::S_IDLE: begin
            pop_cnt_in = '0;
            if (req_kind == stq_pkg::REQ_SCHEDULE) begin
               cmd_ticket = ticket_next;
            end
            if (accept) begin
               unique case (req_kind) inside
                  stq_pkg::REQ_SCHEDULE: begin
                     emit = 1'b1;
                     if (full) begin
                        emit_status = stq_pkg::STAT_FULL;
                     end else begin
                        cmd_op        = stq_pkg::OP_INSERT;
                        ticket_cnt_in = ticket_next;
                        emit_status   = stq_pkg::STAT_SCHEDULED;
                        emit_ticket   = ticket_next;
                     end
                  end
                  stq_pkg::REQ_CANCEL, stq_pkg::REQ_RESCHEDULE: begin
                     emit = 1'b1;
                     if (req_ticket == '0) begin
                        emit_status = stq_pkg::STAT_NO_TICKET;
                     end else if (!found) begin
                        emit_status = stq_pkg::STAT_NOT_FOUND;
                        emit_ticket = req_ticket;
                     end else begin
                        cmd_op          = stq_pkg::OP_REMOVE;
                        emit_ticket     = req_ticket;
                        resch_due_in    = req_due;
                        resch_ticket_in = req_ticket;
                        emit_status     = (req_kind == stq_pkg::REQ_CANCEL) ?
                                          stq_pkg::STAT_CANCELLED :
                                          stq_pkg::STAT_RESCHEDULED;
                     end
                  end
                  stq_pkg::REQ_TICK: begin
                     now_in = req_now;
                  end
                  default: begin
                  end
               endcase
            end
         end
         stq_pkg::S_RESCH: begin
            // The removal freed a cell, so the re-insert always has room.
            cmd_op     = stq_pkg::OP_INSERT;
            cmd_due    = resch_due_ff;
            cmd_ticket = resch_ticket_ff;
         end
         stq_pkg::S_TICK: begin
            if (head_due && out_free) begin
               cmd_op      = stq_pkg::OP_POP;
               emit        = 1'b1;
               emit_status = stq_pkg::STAT_EXPIRED;
               emit_ticket = ticket_arr[0];
               emit_time   = head_wide[PTB-1:0];
               emit_last   = tick_last;
               pop_cnt_in  = pop_cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ticket_in = rsp_ticket_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in  = emit;
         rsp_status_in = emit_status;
         rsp_ticket_in = emit_ticket;
         rsp_time_in   = emit_time;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stq_pkg::S_IDLE;
         ticket_cnt_ff <= '0;
         pop_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ticket_cnt_ff <= ticket_cnt_in;
         pop_cnt_ff    <= pop_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      resch_due_ff    <= resch_due_in;
      resch_ticket_ff <= resch_ticket_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_ticket_ff   <= rsp_ticket_in;
      rsp_time_ff     <= rsp_time_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_time_ff, rsp_ticket_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks.
   logic [QUEUE_DEPTH:0] valid_plus;
   assign valid_plus = {1'b0, valid_vec} + 1'b1;

   // Occupied cells always form the leading part of the row.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot(valid_plus))
      else $error("occupied cells are not contiguous from the head");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == stq_pkg::REQ_SCHEDULE && full)
      |=> (rsp_tvalid && rsp_tuser == stq_pkg::STAT_FULL && !$changed(ticket_cnt_ff)))
      else $error("schedule into a full queue not flagged");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (cmd_op == stq_pkg::OP_POP)
      |=> ($countones(valid_vec) + 1 == $countones($past(valid_vec))))
      else $error("pop did not free exactly one cell");

   a_ticket_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == stq_pkg::STAT_SCHEDULED) |-> (rsp_tdata[31:0] != '0))
      else $error("scheduled timer got ticket zero");

endmodule

`default_nettype wire
